// ----- rtl/core/pbos_pkg.sv -----
// Shared types, constants and helpers for the particle box outline block.
// Used by every module under rtl/core but pbos_recip_div; depends on nothing else.
package pbos_pkg;

  localparam int POS_W       = 24;  // particle centre width
  localparam int SCALE_W     = 16;  // particle scale width
  localparam int DIM_W       = 10;  // box width / height, pixel coordinates
  localparam int COORD_W     = 27;  // signed working width for box edges
  localparam int QUEUE_DEPTH = 4;   // box jobs buffered between front and back

  typedef logic signed [COORD_W-1:0] coord_t;

  // One box to draw: centre, scale and size, plus colour and end-of-item mark
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SCALE_W-1:0]      scale;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic                    best;
    logic                    last;
  } job_t;

  // Clamped box edges held while its four segments go out
  typedef struct packed {
    coord_t x1;
    coord_t x2;
    coord_t y1;
    coord_t y2;
    logic   best;
    logic   last;
  } box_t;

  // Edge order on the output
  typedef enum logic [1:0] {
    SEG_TOP,
    SEG_BOTTOM,
    SEG_LEFT,
    SEG_RIGHT
  } seg_sel_t;

  // Segment has pixels on screen: non-empty span inside along-limit, row/col inside pos-limit
  function automatic logic seg_vis(coord_t a, coord_t b, coord_t pos,
                                   coord_t a_lim, coord_t p_lim);
    logic ok;
    ok = (a <= b) && (a >= coord_t'(0)) && (b <= a_lim - coord_t'(1)) &&
         (pos >= coord_t'(0)) && (pos <= p_lim - coord_t'(1));
    return ok;
  endfunction

endpackage

// ----- rtl/core/pbos_recip_div.sv -----
// Unsigned divide by a constant through one reciprocal multiply, one register.
// Standalone; the quotient is exact for every num below 2**N.
module pbos_recip_div #(
  parameter int N = 25,
  parameter int D = 256
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] num,
  output logic [N-1:0] quo
);

  // M = ceil(2**SH / D) with 2**SH >= D * 2**N makes floor(num*M >> SH) exact
  localparam int          SH  = N + $clog2(D);
  localparam int          MW  = N + 1;
  localparam int          PW  = N + MW;
  localparam logic [63:0] M64 = ((64'd1 << SH) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [MW-1:0] M = M64[MW-1:0];

  logic [PW-1:0] prod;

  // reciprocal product, held while en is low
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(num) * PW'(M);
    end
  end

  assign quo = N'(prod >> SH);

endmodule

// ----- rtl/core/pbos_front.sv -----
// Front end: accepts particles, keeps frame index and sums, forms box jobs.
// Depends on pbos_pkg and pbos_recip_div (mean = sum / PARTICLE_COUNT).
module pbos_front #(
  parameter int PARTICLE_COUNT = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [7:0]                        cfg_data,
  input  logic                              particle_valid,
  output logic                              particle_stall,
  input  logic signed [pbos_pkg::POS_W-1:0] particle_x,
  input  logic signed [pbos_pkg::POS_W-1:0] particle_y,
  input  logic [pbos_pkg::SCALE_W-1:0]      particle_scale,
  input  logic [pbos_pkg::DIM_W-1:0]        box_width,
  input  logic [pbos_pkg::DIM_W-1:0]        box_height,
  input  logic                              q_full,
  output logic                              push,
  output pbos_pkg::job_t                    push_job
);

  localparam int IW  = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;
  localparam int CW  = (IW > 8) ? IW : 8;
  localparam int SSW = pbos_pkg::SCALE_W + $clog2(PARTICLE_COUNT);
  localparam logic [IW-1:0] LAST_IDX = IW'(PARTICLE_COUNT - 1);

  logic [7:0]                    show_count;
  logic [IW-1:0]                 particle_index;
  logic [31:0]                   sum_x;
  logic [31:0]                   sum_y;
  logic [SSW-1:0]                sum_scale;
  logic [pbos_pkg::DIM_W-1:0]    first_width;
  logic [pbos_pkg::DIM_W-1:0]    first_height;

  logic                          accept;
  logic                          shown;
  logic                          frame_end;
  logic [31:0]                   sum_x_next;
  logic [31:0]                   sum_y_next;
  logic [SSW-1:0]                sum_scale_next;
  logic [pbos_pkg::DIM_W-1:0]    width_first;
  logic [pbos_pkg::DIM_W-1:0]    height_first;

  // blue job holding register
  logic                          blue_v;
  pbos_pkg::job_t                blue_job;

  // mean pipeline: r0 holds final sums, r1 holds signs and sizes beside the divider quotients
  logic                          r0_v;
  logic [31:0]                   r0_sx;
  logic [31:0]                   r0_sy;
  logic [SSW-1:0]                r0_ss;
  logic [pbos_pkg::DIM_W-1:0]    r0_w;
  logic [pbos_pkg::DIM_W-1:0]    r0_h;
  logic                          r1_v;
  logic                          r1_nx;
  logic                          r1_ny;
  logic [pbos_pkg::DIM_W-1:0]    r1_w;
  logic [pbos_pkg::DIM_W-1:0]    r1_h;
  logic [31:0]                   mag_x;
  logic [31:0]                   mag_y;
  logic [31:0]                   q_x;
  logic [31:0]                   q_y;
  logic [SSW-1:0]                q_s;
  logic [31:0]                   mean_x;
  logic [31:0]                   mean_y;
  pbos_pkg::job_t                red_job;

  logic                          blue_push;
  logic                          red_push;

  // item classification
  assign accept         = particle_valid && !particle_stall;
  assign shown          = CW'(particle_index) < CW'(show_count);
  assign frame_end      = particle_index == LAST_IDX;
  assign sum_x_next     = sum_x + 32'(particle_x);
  assign sum_y_next     = sum_y + 32'(particle_y);
  assign sum_scale_next = sum_scale + SSW'(particle_scale);
  assign width_first    = (particle_index == '0) ? box_width  : first_width;
  assign height_first   = (particle_index == '0) ? box_height : first_height;

  // hold input while a mean is in flight or a blue job cannot drain
  assign particle_stall = (blue_v && q_full) || r0_v || r1_v;

  // frame state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      show_count     <= '0;
      particle_index <= '0;
      sum_x          <= '0;
      sum_y          <= '0;
      sum_scale      <= '0;
      first_width    <= '0;
      first_height   <= '0;
    end else begin
      if (cfg_write) begin
        show_count <= cfg_data;
      end
      if (accept) begin
        if (frame_end) begin
          particle_index <= '0;
          sum_x          <= '0;
          sum_y          <= '0;
          sum_scale      <= '0;
          first_width    <= '0;
          first_height   <= '0;
        end else begin
          particle_index <= particle_index + IW'(1);
          sum_x          <= sum_x_next;
          sum_y          <= sum_y_next;
          sum_scale      <= sum_scale_next;
          first_width    <= width_first;
          first_height   <= height_first;
        end
      end
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_v <= 1'b0;
      r0_v   <= 1'b0;
      r1_v   <= 1'b0;
    end else begin
      if (accept && shown) begin
        blue_v <= 1'b1;
      end else if (blue_push) begin
        blue_v <= 1'b0;
      end
      r0_v <= accept && frame_end;
      if (r0_v) begin
        r1_v <= 1'b1;
      end else if (red_push) begin
        r1_v <= 1'b0;
      end
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      blue_job.x      <= particle_x;
      blue_job.y      <= particle_y;
      blue_job.scale  <= particle_scale;
      blue_job.width  <= box_width;
      blue_job.height <= box_height;
      blue_job.best   <= 1'b0;
      blue_job.last   <= !frame_end;
      r0_sx           <= sum_x_next;
      r0_sy           <= sum_y_next;
      r0_ss           <= sum_scale_next;
      r0_w            <= width_first;
      r0_h            <= height_first;
    end
    if (r0_v) begin
      r1_nx <= r0_sx[31];
      r1_ny <= r0_sy[31];
      r1_w  <= r0_w;
      r1_h  <= r0_h;
    end
  end

  // mean: magnitude / count, sign restored (truncates toward zero)
  assign mag_x = r0_sx[31] ? (~r0_sx + 32'd1) : r0_sx;
  assign mag_y = r0_sy[31] ? (~r0_sy + 32'd1) : r0_sy;

  pbos_recip_div #(.N(32), .D(PARTICLE_COUNT)) u_mean_x (
    .clk (clk), .en (r0_v), .num (mag_x), .quo (q_x)
  );

  pbos_recip_div #(.N(32), .D(PARTICLE_COUNT)) u_mean_y (
    .clk (clk), .en (r0_v), .num (mag_y), .quo (q_y)
  );

  pbos_recip_div #(.N(SSW), .D(PARTICLE_COUNT)) u_mean_s (
    .clk (clk), .en (r0_v), .num (r0_ss), .quo (q_s)
  );

  assign mean_x = r1_nx ? (32'd0 - q_x) : q_x;
  assign mean_y = r1_ny ? (32'd0 - q_y) : q_y;

  always_comb begin
    red_job.x      = mean_x[pbos_pkg::POS_W-1:0];
    red_job.y      = mean_y[pbos_pkg::POS_W-1:0];
    red_job.scale  = q_s[pbos_pkg::SCALE_W-1:0];
    red_job.width  = r1_w;
    red_job.height = r1_h;
    red_job.best   = 1'b1;
    red_job.last   = 1'b1;
  end

  // queue write: blue box of an item goes ahead of its red box
  assign blue_push = blue_v && !q_full;
  assign red_push  = r1_v && !blue_v && !q_full;
  assign push      = blue_push || red_push;
  assign push_job  = blue_v ? blue_job : red_job;

  // the two mean stages never overlap
  a_mean_single: assert property (@(posedge clk) disable iff (rst) r0_v |-> !r1_v)
    else $error("mean pipeline holds two frames");

  // input is held the cycle after a frame's last particle
  a_frame_end_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> particle_stall)
    else $error("input taken while mean box pending");

endmodule

// ----- rtl/core/pbos_queue.sv -----
// Short job queue between front and back ends.
// Depends on pbos_pkg for job_t and QUEUE_DEPTH.
module pbos_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pbos_pkg::job_t push_job,
  input  logic           pop,
  output pbos_pkg::job_t pop_job,
  output logic           not_empty,
  output logic           full
);

  localparam int AW = $clog2(pbos_pkg::QUEUE_DEPTH);

  pbos_pkg::job_t  entries [pbos_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign not_empty = count != '0;
  assign full      = count == (AW+1)'(pbos_pkg::QUEUE_DEPTH);
  assign pop_job   = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("job queue underflow");

endmodule

// ----- rtl/core/pbos_back.sv -----
// Back end: turns box jobs into clamped edges and plays out four segments.
// Depends on pbos_pkg and pbos_recip_div (divide by GRANULARITY).
module pbos_back #(
  parameter int GRANULARITY   = 256,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_avail,
  input  pbos_pkg::job_t             q_job,
  output logic                       q_pop,
  output logic                       seg_valid,
  input  logic                       seg_stall,
  output logic                       vertical,
  output logic [pbos_pkg::DIM_W-1:0] seg_start,
  output logic [pbos_pkg::DIM_W-1:0] seg_end,
  output logic [pbos_pkg::DIM_W-1:0] seg_pos,
  output logic                       visible,
  output logic                       best_box,
  output logic                       last_segment
);

  localparam int DW = 25;  // dividend width: scale * half size
  localparam pbos_pkg::coord_t SW_LIM = pbos_pkg::coord_t'(SCREEN_WIDTH);
  localparam pbos_pkg::coord_t SH_LIM = pbos_pkg::coord_t'(SCREEN_HEIGHT);

  // stage A: job
  logic                          a_v;
  pbos_pkg::job_t                a_job;
  logic [8:0]                    a_hw;
  logic [8:0]                    a_hh;
  logic [pbos_pkg::POS_W-1:0]    a_xu;
  logic [pbos_pkg::POS_W-1:0]    a_yu;

  // stage B: products and magnitudes
  logic                          b_v;
  logic [DW-1:0]                 b_pw;
  logic [DW-1:0]                 b_ph;
  logic [pbos_pkg::POS_W-1:0]    b_mx;
  logic [pbos_pkg::POS_W-1:0]    b_my;
  logic                          b_nx;
  logic                          b_ny;
  logic                          b_best;
  logic                          b_last;

  // stage C: quotients (inside dividers) and flags
  logic                          c_v;
  logic                          c_nx;
  logic                          c_ny;
  logic                          c_best;
  logic                          c_last;
  logic [DW-1:0]                 q_cx;
  logic [DW-1:0]                 q_cy;
  logic [DW-1:0]                 q_dx;
  logic [DW-1:0]                 q_dy;
  pbos_pkg::coord_t              cx;
  pbos_pkg::coord_t              cy;
  pbos_pkg::coord_t              x1;
  pbos_pkg::coord_t              x2;
  pbos_pkg::coord_t              y1;
  pbos_pkg::coord_t              y2;
  pbos_pkg::box_t                c_box;

  // stage E: segment player
  logic                          e_v;
  pbos_pkg::box_t                e_box;
  pbos_pkg::seg_sel_t            e_sel;
  logic                          e_take;
  logic                          e_done;
  logic                          e_free;

  logic                          a_go;
  logic                          b_go;
  logic                          c_go;

  // segment select outputs
  pbos_pkg::coord_t              s_a;
  pbos_pkg::coord_t              s_b;
  pbos_pkg::coord_t              s_pos;
  pbos_pkg::coord_t              s_alim;
  pbos_pkg::coord_t              s_plim;
  logic                          s_vert;
  logic                          s_vis;

  // pipeline handshake, one box per stage
  assign e_take = e_v && !seg_stall;
  assign e_done = e_take && (e_sel == pbos_pkg::SEG_RIGHT);
  assign e_free = !e_v || e_done;
  assign c_go   = c_v && e_free;
  assign b_go   = b_v && (!c_v || c_go);
  assign a_go   = a_v && (!b_v || b_go);
  assign q_pop  = q_avail && (!a_v || a_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v   <= 1'b0;
      b_v   <= 1'b0;
      c_v   <= 1'b0;
      e_v   <= 1'b0;
      e_sel <= pbos_pkg::SEG_TOP;
    end else begin
      if (q_pop) begin
        a_v <= 1'b1;
      end else if (a_go) begin
        a_v <= 1'b0;
      end
      if (a_go) begin
        b_v <= 1'b1;
      end else if (b_go) begin
        b_v <= 1'b0;
      end
      if (b_go) begin
        c_v <= 1'b1;
      end else if (c_go) begin
        c_v <= 1'b0;
      end
      if (c_go) begin
        e_v   <= 1'b1;
        e_sel <= pbos_pkg::SEG_TOP;
      end else if (e_done) begin
        e_v <= 1'b0;
      end else if (e_take) begin
        e_sel <= pbos_pkg::seg_sel_t'(e_sel + 2'd1);
      end
    end
  end

  // stage A logic: half sizes (zero size collapses to centre), magnitudes
  assign a_hw = (a_job.width == '0) ? 9'd0 : 9'((a_job.width - 10'd1) >> 1);
  assign a_hh = (a_job.height == '0) ? 9'd0 : 9'((a_job.height - 10'd1) >> 1);
  assign a_xu = a_job.x;
  assign a_yu = a_job.y;

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_job <= q_job;
    end
    if (a_go) begin
      b_pw   <= DW'(a_job.scale) * DW'(a_hw);
      b_ph   <= DW'(a_job.scale) * DW'(a_hh);
      b_mx   <= a_xu[pbos_pkg::POS_W-1] ? (~a_xu + 24'd1) : a_xu;
      b_my   <= a_yu[pbos_pkg::POS_W-1] ? (~a_yu + 24'd1) : a_yu;
      b_nx   <= a_xu[pbos_pkg::POS_W-1];
      b_ny   <= a_yu[pbos_pkg::POS_W-1];
      b_best <= a_job.best;
      b_last <= a_job.last;
    end
    if (b_go) begin
      c_nx   <= b_nx;
      c_ny   <= b_ny;
      c_best <= b_best;
      c_last <= b_last;
    end
    if (c_go) begin
      e_box <= c_box;
    end
  end

  // divide centre and extents by the granularity
  pbos_recip_div #(.N(DW), .D(GRANULARITY)) u_div_cx (
    .clk (clk), .en (b_go), .num (DW'(b_mx)), .quo (q_cx)
  );

  pbos_recip_div #(.N(DW), .D(GRANULARITY)) u_div_cy (
    .clk (clk), .en (b_go), .num (DW'(b_my)), .quo (q_cy)
  );

  pbos_recip_div #(.N(DW), .D(GRANULARITY)) u_div_dx (
    .clk (clk), .en (b_go), .num (b_pw), .quo (q_dx)
  );

  pbos_recip_div #(.N(DW), .D(GRANULARITY)) u_div_dy (
    .clk (clk), .en (b_go), .num (b_ph), .quo (q_dy)
  );

  // edges and screen clamps
  always_comb begin
    cx = c_nx ? -pbos_pkg::coord_t'(q_cx) : pbos_pkg::coord_t'(q_cx);
    cy = c_ny ? -pbos_pkg::coord_t'(q_cy) : pbos_pkg::coord_t'(q_cy);
    x1 = cx - pbos_pkg::coord_t'(q_dx);
    x2 = cx + pbos_pkg::coord_t'(q_dx);
    y1 = cy - pbos_pkg::coord_t'(q_dy);
    y2 = cy + pbos_pkg::coord_t'(q_dy);
    c_box.x1   = (x1 < pbos_pkg::coord_t'(0)) ? pbos_pkg::coord_t'(0) : x1;
    c_box.x2   = (x2 > SW_LIM - pbos_pkg::coord_t'(1)) ? SW_LIM - pbos_pkg::coord_t'(1) : x2;
    c_box.y1   = (y1 < pbos_pkg::coord_t'(0)) ? pbos_pkg::coord_t'(0) : y1;
    c_box.y2   = (y2 > SH_LIM - pbos_pkg::coord_t'(1)) ? SH_LIM - pbos_pkg::coord_t'(1) : y2;
    c_box.best = c_best;
    c_box.last = c_last;
  end

  // current segment of the held box
  always_comb begin
    case (e_sel)
      pbos_pkg::SEG_TOP: begin
        s_vert = 1'b0; s_a = e_box.x1; s_b = e_box.x2; s_pos = e_box.y1;
        s_alim = SW_LIM; s_plim = SH_LIM;
      end
      pbos_pkg::SEG_BOTTOM: begin
        s_vert = 1'b0; s_a = e_box.x1; s_b = e_box.x2; s_pos = e_box.y2;
        s_alim = SW_LIM; s_plim = SH_LIM;
      end
      pbos_pkg::SEG_LEFT: begin
        s_vert = 1'b1; s_a = e_box.y1; s_b = e_box.y2; s_pos = e_box.x1;
        s_alim = SH_LIM; s_plim = SW_LIM;
      end
      pbos_pkg::SEG_RIGHT: begin
        s_vert = 1'b1; s_a = e_box.y1; s_b = e_box.y2; s_pos = e_box.x2;
        s_alim = SH_LIM; s_plim = SW_LIM;
      end
      default: begin
        s_vert = 1'b0; s_a = '0; s_b = '0; s_pos = '0;
        s_alim = SW_LIM; s_plim = SH_LIM;
      end
    endcase
    s_vis = pbos_pkg::seg_vis(s_a, s_b, s_pos, s_alim, s_plim);
  end

  // output beat
  assign seg_valid    = e_v;
  assign vertical     = s_vert;
  assign visible      = s_vis;
  assign seg_start    = s_vis ? s_a[pbos_pkg::DIM_W-1:0] : '0;
  assign seg_end      = s_vis ? s_b[pbos_pkg::DIM_W-1:0] : '0;
  assign seg_pos      = s_vis ? s_pos[pbos_pkg::DIM_W-1:0] : '0;
  assign best_box     = e_box.best;
  assign last_segment = e_box.last && (e_sel == pbos_pkg::SEG_RIGHT);

  // a finished box with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (e_done && !c_go) |=> !seg_valid)
    else $error("segment player kept a finished box");

  // a new box always starts on its top edge
  a_box_start: assert property (@(posedge clk) disable iff (rst)
    c_go |=> (seg_valid && e_sel == pbos_pkg::SEG_TOP))
    else $error("box loaded off its first edge");

endmodule

// ----- rtl/core/particle_box_outline_segments.sv -----
// A shown particle passes the blue job register, the job queue and stages A, B, C
// and E to its first segment beat. Throughput: one segment beat per cycle while
// seg_stall is low; a blue box gives four beats, a hidden particle none; a frame's
// last particle adds a red mean box (4 beats) and holds input till it is queued.
// Reset (synchronous, active high) clears show_count, frame index, sums, queue
// and all pipeline valid flags; no clearing pass is needed.
module particle_box_outline_segments #(
  parameter int PARTICLE_COUNT = 128,
  parameter int GRANULARITY    = 256,
  parameter int SCREEN_WIDTH   = 640,
  parameter int SCREEN_HEIGHT  = 480
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [7:0]                        cfg_data,
  input  logic                              particle_valid,
  output logic                              particle_stall,
  input  logic signed [pbos_pkg::POS_W-1:0] particle_x,
  input  logic signed [pbos_pkg::POS_W-1:0] particle_y,
  input  logic [pbos_pkg::SCALE_W-1:0]      particle_scale,
  input  logic [pbos_pkg::DIM_W-1:0]        box_width,
  input  logic [pbos_pkg::DIM_W-1:0]        box_height,
  output logic                              seg_valid,
  input  logic                              seg_stall,
  output logic                              vertical,
  output logic [pbos_pkg::DIM_W-1:0]        seg_start,
  output logic [pbos_pkg::DIM_W-1:0]        seg_end,
  output logic [pbos_pkg::DIM_W-1:0]        seg_pos,
  output logic                              visible,
  output logic                              best_box,
  output logic                              last_segment
);

  logic           q_push;
  pbos_pkg::job_t q_push_job;
  logic           q_pop;
  pbos_pkg::job_t q_pop_job;
  logic           q_avail;
  logic           q_full;

  // classify particles, keep frame sums, build box jobs
  pbos_front #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .particle_valid (particle_valid),
    .particle_stall (particle_stall),
    .particle_x     (particle_x),
    .particle_y     (particle_y),
    .particle_scale (particle_scale),
    .box_width      (box_width),
    .box_height     (box_height),
    .q_full         (q_full),
    .push           (q_push),
    .push_job       (q_push_job)
  );

  // job buffer
  pbos_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .pop       (q_pop),
    .pop_job   (q_pop_job),
    .not_empty (q_avail),
    .full      (q_full)
  );

  // box geometry and segment output
  pbos_back #(
    .GRANULARITY   (GRANULARITY),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_avail      (q_avail),
    .q_job        (q_pop_job),
    .q_pop        (q_pop),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .vertical     (vertical),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .seg_pos      (seg_pos),
    .visible      (visible),
    .best_box     (best_box),
    .last_segment (last_segment)
  );

endmodule

// ----- test/tb_particle_box_outline_segments.sv -----
// Self-checking testbench for particle_box_outline_segments: directed table plus random frames,
// each segment beat checked against a behavioral outline predictor or typed table edges.
// Depends on rtl/core/pbos_pkg.sv and rtl/core/particle_box_outline_segments.sv.
`timescale 1ns / 1ps

module tb_particle_box_outline_segments;

  localparam int     POS_W       = pbos_pkg::POS_W;
  localparam int     SCALE_W     = pbos_pkg::SCALE_W;
  localparam int     DIM_W       = pbos_pkg::DIM_W;
  localparam int     PARTICLES   = 128;
  localparam int     GRAN_STEPS  = 256;
  localparam int     SCR_W       = 640;
  localparam int     SCR_H       = 480;
  localparam longint PCOUNT      = PARTICLES;
  localparam longint GRAN        = GRAN_STEPS;
  localparam longint SW          = SCR_W;
  localparam longint SH          = SCR_H;
  localparam int     QUIET       = 24;    // covers latency plus the mean divide
  localparam int     HOLD_CYCLES = 300;   // long output back-pressure stretch
  localparam int     WATCHDOG    = 3000;
  localparam int     PLAN_ROWS   = 19;
  localparam int     PHASES      = 7;
  localparam int     PHASE_ITEMS = 64;

  // One segment beat as seen on the output
  typedef struct packed {
    logic             vert;
    logic [DIM_W-1:0] lo;
    logic [DIM_W-1:0] hi;
    logic [DIM_W-1:0] pos;
    logic             vis;
    logic             red;
    logic             last;
  } seg_t;

  // How a table row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,  // predictor output
    CHK_NONE,   // typed: no beats at all
    CHK_BOX     // typed: four blue edges
  } chk_t;

  typedef struct packed {
    logic                    wr_cfg;
    logic [7:0]              cfg;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SCALE_W-1:0]      s;
    logic [DIM_W-1:0]        w;
    logic [DIM_W-1:0]        h;
    chk_t                    chk;
    seg_t [3:0]              segs;
  } row_t;

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    cfg_write      = 1'b0;
  logic [7:0]              cfg_data       = '0;
  logic                    particle_valid = 1'b0;
  logic                    particle_stall;
  logic signed [POS_W-1:0] particle_x     = '0;
  logic signed [POS_W-1:0] particle_y     = '0;
  logic [SCALE_W-1:0]      particle_scale = '0;
  logic [DIM_W-1:0]        box_width      = '0;
  logic [DIM_W-1:0]        box_height     = '0;
  logic                    seg_valid;
  logic                    seg_stall      = 1'b0;
  logic                    vertical;
  logic [DIM_W-1:0]        seg_start;
  logic [DIM_W-1:0]        seg_end;
  logic [DIM_W-1:0]        seg_pos;
  logic                    visible;
  logic                    best_box;
  logic                    last_segment;

  // Predictor state
  int          show_now  = 0;
  int          frame_pos = 0;
  logic [31:0] acc_x     = '0;
  logic [31:0] acc_y     = '0;
  logic [31:0] acc_s     = '0;
  int          first_w   = 0;
  int          first_h   = 0;

  seg_t segs_due[$];
  int   seg_errors  = 0;
  int   idle_cycles = 0;
  int   hold_asks   = 0;
  int   hold_seen;
  int   sink_wait;
  int   sink_hold;
  logic gaps_in     = 1'b1;
  logic gaps_out    = 1'b1;

  row_t       plan [0:PLAN_ROWS-1];
  logic [7:0] phase_show [0:PHASES-1] = '{8'd128, 8'd0, 8'd255, 8'd64, 8'd0, 8'd1, 8'd127};

  particle_box_outline_segments #(
    .PARTICLE_COUNT(PARTICLES),
    .GRANULARITY   (GRAN_STEPS),
    .SCREEN_WIDTH  (SCR_W),
    .SCREEN_HEIGHT (SCR_H)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .particle_valid(particle_valid),
    .particle_stall(particle_stall),
    .particle_x    (particle_x),
    .particle_y    (particle_y),
    .particle_scale(particle_scale),
    .box_width     (box_width),
    .box_height    (box_height),
    .seg_valid     (seg_valid),
    .seg_stall     (seg_stall),
    .vertical      (vertical),
    .seg_start     (seg_start),
    .seg_end       (seg_end),
    .seg_pos       (seg_pos),
    .visible       (visible),
    .best_box      (best_box),
    .last_segment  (last_segment)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // One edge; fields read as zero when nothing lands on screen
  function automatic seg_t seg_of(input bit vert, input longint a, b, pos, a_lim, p_lim,
                                  input bit red, last);
    seg_t e;
    bit   on;
    on = (a <= b) && (a >= 0) && (b <= a_lim - 1) && (pos >= 0) && (pos <= p_lim - 1);
    e = '0;
    e.vert = vert;
    e.red  = red;
    e.last = last;
    if (on) begin
      e.lo  = a[DIM_W-1:0];
      e.hi  = b[DIM_W-1:0];
      e.pos = pos[DIM_W-1:0];
      e.vis = 1'b1;
    end
    return e;
  endfunction

  // Scaled, clamped box as top, bottom, left, right
  function automatic void add_box(input longint x, y, s, w, h, input bit red, last,
                                  inout seg_t [7:0] res, inout int n);
    longint hw, hh, dx, dy, x1, x2, y1, y2;
    hw = (w >= 1) ? (w - 1) / 2 : 0;
    hh = (h >= 1) ? (h - 1) / 2 : 0;
    dx = (s * hw) / GRAN;
    dy = (s * hh) / GRAN;
    x1 = x / GRAN - dx;
    x2 = x / GRAN + dx;
    y1 = y / GRAN - dy;
    y2 = y / GRAN + dy;
    if (x1 < 0) x1 = 0;
    if (x2 > SW - 1) x2 = SW - 1;
    if (y1 < 0) y1 = 0;
    if (y2 > SH - 1) y2 = SH - 1;
    res[n]     = seg_of(1'b0, x1, x2, y1, SW, SH, red, 1'b0);
    res[n + 1] = seg_of(1'b0, x1, x2, y2, SW, SH, red, 1'b0);
    res[n + 2] = seg_of(1'b1, y1, y2, x1, SH, SW, red, 1'b0);
    res[n + 3] = seg_of(1'b1, y1, y2, x2, SH, SW, red, last);
    n += 4;
  endfunction

  // Blue box while inside show_count, frame sums, red mean box on the frame's last particle
  function automatic void outline_model(input row_t r, output seg_t [7:0] res, output int n);
    longint x, y, mx, my, ms;
    bit     frame_end;
    n   = 0;
    res = '0;
    x   = $signed(r.x);
    y   = $signed(r.y);
    frame_end = (frame_pos >= PCOUNT - 1);
    if (frame_pos < show_now) add_box(x, y, r.s, r.w, r.h, 1'b0, !frame_end, res, n);
    if (frame_pos == 0) begin
      first_w = r.w;
      first_h = r.h;
    end
    acc_x += x[31:0];
    acc_y += y[31:0];
    acc_s += {16'd0, r.s};
    if (frame_end) begin
      mx = $signed(acc_x);
      my = $signed(acc_y);
      ms = $signed(acc_s);
      add_box(mx / PCOUNT, my / PCOUNT, ms / PCOUNT, first_w, first_h, 1'b1, 1'b1, res, n);
      frame_pos = 0;
      acc_x     = '0;
      acc_y     = '0;
      acc_s     = '0;
      first_w   = 0;
      first_h   = 0;
    end else begin
      frame_pos++;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic seg_t edge_at(input bit vert, input int lo, hi, pos, input bit vis);
    seg_t e;
    e      = '0;
    e.vert = vert;
    e.lo   = DIM_W'(lo);
    e.hi   = DIM_W'(hi);
    e.pos  = DIM_W'(pos);
    e.vis  = vis;
    return e;
  endfunction

  function automatic row_t mk_row(input bit wr, input int cfg, x, y, s, w, h, input chk_t chk,
                                  input seg_t top, bot, lft, rgt);
    row_t r;
    r         = '0;
    r.wr_cfg  = wr;
    r.cfg     = 8'(cfg);
    r.x       = POS_W'(x);
    r.y       = POS_W'(y);
    r.s       = SCALE_W'(s);
    r.w       = DIM_W'(w);
    r.h       = DIM_W'(h);
    r.chk     = chk;
    r.segs[0] = top;
    r.segs[1] = bot;
    r.segs[2] = lft;
    r.segs[3] = rgt;
    r.segs[3].last = 1'b1;
    return r;
  endfunction

  // Mostly on-screen particles with moderate scale, some full-range noise
  function automatic row_t random_row();
    row_t r;
    int   px, py;
    r     = '0;
    r.chk = CHK_MODEL;
    if ($urandom_range(0, 9) == 0) begin
      r.x = POS_W'($urandom());
      r.y = POS_W'($urandom());
      r.s = SCALE_W'($urandom());
      r.w = DIM_W'($urandom());
      r.h = DIM_W'($urandom());
    end else begin
      px  = $urandom_range(0, 720);
      py  = $urandom_range(0, 560);
      r.x = POS_W'(px * 256 + $urandom_range(0, 255) - 40 * 256);
      r.y = POS_W'(py * 256 + $urandom_range(0, 255) - 40 * 256);
      r.s = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(0, 65535))
                                        : SCALE_W'($urandom_range(0, 767));
      r.w = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 1023))
                                        : DIM_W'($urandom_range(0, 80));
      r.h = ($urandom_range(0, 3) == 0) ? DIM_W'($urandom_range(0, 1023))
                                        : DIM_W'($urandom_range(0, 80));
    end
    return r;
  endfunction

  function automatic string seg_text(input seg_t e);
    return $sformatf("vertical=%0d start=%0d end=%0d pos=%0d visible=%0d best=%0d last=%0d",
                     e.vert, e.lo, e.hi, e.pos, e.vis, e.red, e.last);
  endfunction

  // Offer one particle, hold it until taken, then log its expected beats
  task automatic send_particle(input row_t r);
    seg_t [7:0] res;
    int         n, gap, i;
    particle_valid <= 1'b1;
    particle_x     <= r.x;
    particle_y     <= r.y;
    particle_scale <= r.s;
    box_width      <= r.w;
    box_height     <= r.h;
    do @(posedge clk); while (particle_stall);
    outline_model(r, res, n);
    case (r.chk)
      CHK_MODEL: for (i = 0; i < n; i++) segs_due.push_back(res[i]);
      CHK_BOX:   for (i = 0; i < 4; i++) segs_due.push_back(r.segs[i]);
      default:   ;
    endcase
    gap = gaps_in ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      particle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Idle the block: all beats out, then room for a hidden particle still in flight
  task automatic settle();
    particle_valid <= 1'b0;
    while (segs_due.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_show_count(input logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    show_now = v;
  endtask

  // ---------------------------------------------------------------- output side

  // Check each beat against the oldest expectation and drive random stall
  always @(posedge clk) begin : seg_sink
    seg_t got, want;
    int   pause;
    if (rst) begin
      seg_stall <= 1'b0;
      sink_wait <= 0;
      sink_hold <= 0;
      hold_seen <= 0;
    end else begin
      if (seg_valid && !seg_stall) begin
        got = {vertical, seg_start, seg_end, seg_pos, visible, best_box, last_segment};
        if (segs_due.size() == 0) begin
          seg_errors++;
          if (seg_errors <= 10) $display("unexpected beat: %s", seg_text(got));
        end else begin
          want = segs_due.pop_front();
          if (got !== want) begin
            seg_errors++;
            if (seg_errors <= 10)
              $display("segment mismatch\n  expected %s\n  actual   %s",
                       seg_text(want), seg_text(got));
          end
        end
      end

      // stall: long hold on request, else a random wait after each beat
      if (sink_hold != 0) begin
        seg_stall <= 1'b1;
        sink_hold <= sink_hold - 1;
      end else if (hold_asks != hold_seen) begin
        seg_stall <= 1'b1;
        sink_hold <= HOLD_CYCLES - 1;
        hold_seen <= hold_asks;
      end else if (sink_wait != 0) begin
        seg_stall <= 1'b1;
        sink_wait <= sink_wait - 1;
      end else if (seg_valid && !seg_stall) begin
        pause = gaps_out ? $urandom_range(0, 9) : 0;
        seg_stall <= (pause != 0);
        sink_wait <= (pause == 0) ? 0 : pause - 1;
      end else begin
        seg_stall <= 1'b0;
      end
    end
  end

  // Watchdog: no beat on either side for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((particle_valid && !particle_stall) || (seg_valid && !seg_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG - 1) begin
      $display("watchdog: no beat for %0d cycles, %0d segments pending",
               WATCHDOG, segs_due.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    seg_t h0, hx, v0, vx;
    int   k, ph;
    h0 = edge_at(1'b0, 0, 0, 0, 1'b1);
    hx = edge_at(1'b0, 0, 0, 0, 1'b0);
    v0 = edge_at(1'b1, 0, 0, 0, 1'b1);
    vx = edge_at(1'b1, 0, 0, 0, 1'b0);

    // directed rows; show_count is 0 out of reset, so the first particle is hidden
    plan[0]  = mk_row(0, 0, 1000, 1000, 256, 10, 10, CHK_NONE, hx, hx, vx, vx);
    // all-zero particle collapses to one pixel at the origin
    plan[1]  = mk_row(1, 255, 0, 0, 0, 0, 0, CHK_BOX, h0, h0, v0, v0);
    // centre extremes: only the edge on the clamped side survives
    plan[2]  = mk_row(0, 0, 8388607, 0, 0, 0, 0, CHK_BOX,
                      hx, hx, vx, edge_at(1'b1, 0, 0, 639, 1'b1));
    plan[3]  = mk_row(0, 0, -8388608, 0, 0, 0, 0, CHK_BOX, hx, hx, v0, vx);
    plan[4]  = mk_row(0, 0, 0, 8388607, 0, 0, 0, CHK_BOX,
                      hx, edge_at(1'b0, 0, 0, 479, 1'b1), vx, vx);
    plan[5]  = mk_row(0, 0, 0, -8388608, 0, 0, 0, CHK_BOX, h0, hx, vx, vx);
    // huge box clamped to the full screen
    plan[6]  = mk_row(0, 0, 81920, 61440, 65535, 1023, 1023, CHK_BOX,
                      edge_at(1'b0, 0, 639, 0, 1'b1), edge_at(1'b0, 0, 639, 479, 1'b1),
                      edge_at(1'b1, 0, 479, 0, 1'b1), edge_at(1'b1, 0, 479, 639, 1'b1));
    // ordinary unit-scale box
    plan[7]  = mk_row(0, 0, 25600, 12800, 256, 101, 51, CHK_BOX,
                      edge_at(1'b0, 50, 150, 25, 1'b1), edge_at(1'b0, 50, 150, 75, 1'b1),
                      edge_at(1'b1, 25, 75, 50, 1'b1), edge_at(1'b1, 25, 75, 150, 1'b1));
    // small negative centre truncates toward zero
    plan[8]  = mk_row(0, 0, -1, -255, 0, 0, 0, CHK_BOX, h0, h0, v0, v0);
    plan[9]  = mk_row(0, 0, -256, 0, 0, 0, 0, CHK_BOX, hx, hx, v0, vx);
    // zero width and height: full scale still collapses to the centre
    plan[10] = mk_row(0, 0, 25600, 25600, 65535, 0, 0, CHK_BOX,
                      edge_at(1'b0, 100, 100, 100, 1'b1), edge_at(1'b0, 100, 100, 100, 1'b1),
                      edge_at(1'b1, 100, 100, 100, 1'b1), edge_at(1'b1, 100, 100, 100, 1'b1));
    plan[11] = mk_row(0, 0, 160000, 100000, 300, 1, 2, CHK_MODEL, hx, hx, vx, vx);
    plan[12] = mk_row(0, 0, -5000, 70000, 65535, 2, 3, CHK_MODEL, hx, hx, vx, vx);
    plan[13] = mk_row(0, 0, 163583, 122623, 1000, 1023, 0, CHK_MODEL, hx, hx, vx, vx);
    // show_count below the frame position: nothing drawn
    plan[14] = mk_row(1, 3, 0, 0, 65535, 1023, 1023, CHK_NONE, hx, hx, vx, vx);
    plan[15] = mk_row(0, 0, 8388607, -8388608, 0, 1023, 1023, CHK_NONE, hx, hx, vx, vx);
    plan[16] = mk_row(1, 128, 50000, 50000, 512, 40, 30, CHK_MODEL, hx, hx, vx, vx);
    plan[17] = mk_row(0, 0, -8388608, 8388607, 65535, 1023, 1023, CHK_MODEL, hx, hx, vx, vx);
    plan[18] = mk_row(0, 0, 8388607, -8388608, 1, 511, 512, CHK_MODEL, hx, hx, vx, vx);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].wr_cfg) begin
        settle();
        write_show_count(plan[k].cfg);
      end
      send_particle(plan[k]);
    end

    // random frames under several show_count settings and idle patterns
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_show_count((ph == 4) ? 8'($urandom_range(2, 254)) : phase_show[ph]);
      gaps_in  <= (ph % 4 == 1) || (ph % 4 == 2);
      gaps_out <= (ph % 4 == 0) || (ph % 4 == 2);
      // fill the block against a held-off output
      if (phase_show[ph] == 8'd255) hold_asks <= hold_asks + 1;
      for (k = 0; k < PHASE_ITEMS; k++) send_particle(random_row());
    end

    settle();
    if (seg_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
